[design/sida_pkg.sv]
// shared constants and types for the signed integer to decimal text block
package sida_pkg;

  localparam int VALW   = 32;               // input word width
  localparam int NDIG   = 10;               // decimal digits of a 32-bit magnitude
  localparam int DIGW   = 4;                // one bcd digit
  localparam int IDXW   = $clog2(NDIG);     // digit index
  localparam int CNTW   = $clog2(VALW);     // conversion step counter
  localparam int CHARW  = 8;
  localparam int QDEPTH = 2;                // front to back queue depth
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [CHARW-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHARW-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHARW-1:0] ASCII_NINE  = 8'h39;

  // one classified word: sign and unsigned magnitude
  typedef struct packed {
    logic            neg;
    logic [VALW-1:0] mag;
  } job_t;

  typedef logic [NDIG-1:0][DIGW-1:0] bcd_t;

endpackage

[design/sida_front.sv]
// input side: sign split, magnitude and a short queue toward the converter
module sida_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic signed [sida_pkg::VALW-1:0] value_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output sida_pkg::job_t              job_o
);
  import sida_pkg::*;

  job_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           wr_en, rd_en;
  job_t           new_job;
  logic [VALW-1:0] raw;

  assign raw          = $unsigned(value_i);
  assign new_job.neg  = raw[VALW-1];
  assign new_job.mag  = raw[VALW-1] ? (VALW'(0) - raw) : raw;

  assign full        = (cnt_q == QCW'(QDEPTH));
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_job;
    end
  end

endmodule

[design/sida_back.sv]
// output side: shift-and-add-3 conversion, then one character per cycle while the output is free
module sida_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  sida_pkg::job_t                job_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sida_pkg::CHARW-1:0]    char_code_o,
  output logic                          last_o
);
  import sida_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_LEAD = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNTW-1:0]  step_q, step_d;
  logic [VALW-1:0]  bin_q, bin_d;
  bcd_t             bcd_q, bcd_d;
  logic             neg_q, neg_d;
  logic [IDXW-1:0]  idx_q, idx_d;
  logic             oval_q, oval_d;
  logic [CHARW-1:0] och_q, och_d;
  logic             olast_q, olast_d;

  bcd_t             adj;
  logic [NDIG*DIGW-1:0] adj_flat;
  logic [IDXW-1:0]  msd;
  logic             out_free;
  logic             emit;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_q[i] >= DIGW'(5)) ? bcd_q[i] + DIGW'(3) : bcd_q[i];
    end
  end
  assign adj_flat = adj;

  // most significant nonzero digit, zero when all digits are zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i] != '0) begin
        msd = IDXW'(i);
      end
    end
  end

  assign out_free    = !oval_q || pop;
  assign job_ready_o = (state_q == ST_IDLE);
  assign emit        = (state_q == ST_EMIT) && out_free;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    oval_d  = oval_q && !pop;
    och_d   = och_q;
    olast_d = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          bin_d   = job_i.mag;
          neg_d   = job_i.neg;
          bcd_d   = '0;
          step_d  = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d  = {adj_flat[NDIG*DIGW-2:0], bin_q[VALW-1]};
        bin_d  = {bin_q[VALW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == CNTW'(VALW - 1)) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_d   = msd;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          oval_d = 1'b1;
          if (neg_q) begin
            och_d   = ASCII_MINUS;
            olast_d = 1'b0;
            neg_d   = 1'b0;
          end else begin
            och_d   = ASCII_ZERO + {{(CHARW-DIGW){1'b0}}, bcd_q[idx_q]};
            olast_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    idx_q   <= idx_d;
    och_q   <= och_d;
    olast_q <= olast_d;
  end

  assign empty       = !oval_q;
  assign char_code_o = och_q;
  assign last_o      = olast_q;

endmodule

[design/signed_int_to_decimal_ascii_top.sv]
// top level of the signed 32-bit integer to decimal ascii text block
// Each word pushed is a 32-bit two's complement integer; the block pops out
// its decimal text one ascii character per pop, most significant digit
// first, with a leading '-' for negative values, no leading zeros, a single
// '0' for zero, and last set on the final character. The most negative value
// prints as "-2147483648" like any other. In the converter a word is loaded,
// runs through 32 shift-and-add-3 steps over the magnitude bits, has its
// leading digit located, and then gives out its characters (up to 11) one
// at a time, all in the single iterative bcd converter. A finished character
// still waiting to be popped stalls the character output. A two-entry queue
// in front lets new words be pushed while a number is being converted, and
// an output register lets the converter run while a character waits to be
// popped. No clearing pass after reset.
module signed_int_to_decimal_ascii_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input queue side
  input  logic                              push,
  output logic                              full,
  input  logic signed [sida_pkg::VALW-1:0]  value_i,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output logic [sida_pkg::CHARW-1:0]        char_code_o,
  output logic                              last_o
);
  import sida_pkg::*;

  // classified word handed from front to back
  job_t job;
  logic job_valid;
  logic job_ready;

  // front: sign split, magnitude, queue
  sida_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // back: bcd conversion and character output register
  sida_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

[design/sida_checker.sv]
// port-level checks for the decimal text block, bound to the top level
module sida_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              empty,
  input logic                              pop,
  input logic [sida_pkg::CHARW-1:0]        char_code_o,
  input logic                              last_o
);
  import sida_pkg::*;

  // a waiting character holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(char_code_o) && $stable(last_o)))
    else $error("result word changed while stalled");

  // only a minus sign or a digit comes out
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (char_code_o == ASCII_MINUS ||
                (char_code_o >= ASCII_ZERO && char_code_o <= ASCII_NINE)))
    else $error("character is neither minus nor digit");

  // a sign never ends a number
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_code_o == ASCII_MINUS) |-> !last_o)
    else $error("minus sign flagged last");

  // a sign is followed by a digit, never by another sign
  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && char_code_o == ASCII_MINUS) |=>
      (empty || char_code_o != ASCII_MINUS))
    else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (.*);
